// ===== rtl/irpcp_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package irpcp_pkg;

    localparam int unsigned STORE_DEPTH_DEF = 256;
    localparam int unsigned WORD_W          = 16;
    localparam int unsigned CARRIER_W       = 8;
    localparam int unsigned CFG_IDX_W       = 2;

    localparam logic [WORD_W-1:0]    START_MARKER_RST = 16'd32766;
    localparam logic [WORD_W-1:0]    STOP_MARKER_RST  = 16'd32765;
    localparam logic [CARRIER_W-1:0] CARRIER_PER_RST  = 8'd26;
    localparam logic [CARRIER_W-1:0] CARRIER_HIGH_RST = 8'd13;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_START_MARKER = 2'd0,
        CFG_STOP_MARKER  = 2'd1,
        CFG_CARRIER_PER  = 2'd2,
        CFG_CARRIER_HIGH = 2'd3
    } t_cfg_reg;

    typedef enum logic [1:0] {
        K_TICK  = 2'd0,
        K_START = 2'd1,
        K_STOP  = 2'd2,
        K_DATA  = 2'd3
    } t_kind;

    typedef struct packed {
        t_kind             kind;
        logic [WORD_W-1:0] word;
    } t_cmd;

    typedef struct packed {
        logic valid;
        t_cmd cmd;
    } t_qhead;

endpackage

`default_nettype wire

// ===== rtl/irpcp_in_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface irpcp_in_if;
    logic        valid;
    logic        ready;
    logic        operation;
    logic [15:0] word_in;

    modport source (output valid, output operation, output word_in, input ready);
    modport sink   (input valid, input operation, input word_in, output ready);
endinterface

`default_nettype wire

// ===== rtl/irpcp_out_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface irpcp_out_if;
    logic        valid;
    logic        ready;
    logic        ir_drive;
    logic        capture_led;
    logic        echo_valid;
    logic [15:0] echo_word;
    logic        word_ignored;
    logic        playing;
    logic        done_res;

    modport source (
        output valid, output ir_drive, output capture_led, output echo_valid,
        output echo_word, output word_ignored, output playing, output done_res,
        input ready
    );
    modport sink (
        input valid, input ir_drive, input capture_led, input echo_valid,
        input echo_word, input word_ignored, input playing, input done_res,
        output ready
    );
endinterface

`default_nettype wire

// ===== rtl/irpcp_front.sv =====
`timescale 1ns / 1ps
`default_nettype none

module irpcp_front (
    input  wire                               i_clk,
    input  wire                               i_rst_n,
    irpcp_in_if.sink                          i_in,
    input  wire  [irpcp_pkg::WORD_W-1:0]      i_start_marker,
    input  wire  [irpcp_pkg::WORD_W-1:0]      i_stop_marker,
    input  wire                               i_pop,
    output irpcp_pkg::t_qhead                 o_head
);

    irpcp_pkg::t_cmd r_q [2];
    logic            r_wp;
    logic            r_rp;
    logic [1:0]      r_cnt;
    irpcp_pkg::t_cmd n_cmd;
    logic            push;
    logic            pop;

    assign i_in.ready = (r_cnt != 2'd2);
    assign push       = i_in.valid && i_in.ready;
    assign pop        = i_pop && (r_cnt != 2'd0);

    always_comb begin
        n_cmd.word = i_in.word_in;
        if (i_in.operation) begin
            n_cmd.kind = irpcp_pkg::K_TICK;
        end else if (i_in.word_in == i_start_marker) begin
            n_cmd.kind = irpcp_pkg::K_START;
        end else if (i_in.word_in == i_stop_marker) begin
            n_cmd.kind = irpcp_pkg::K_STOP;
        end else begin
            n_cmd.kind = irpcp_pkg::K_DATA;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= n_cmd;
        end
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) begin
                r_wp <= ~r_wp;
            end
            if (pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + {1'b0, push} - {1'b0, pop};
        end
    end

    assign o_head.valid = (r_cnt != 2'd0);
    assign o_head.cmd   = r_q[r_rp];

endmodule

`default_nettype wire

// ===== rtl/irpcp_back.sv =====
`timescale 1ns / 1ps
`default_nettype none

module irpcp_back #(
    parameter int unsigned STORE_DEPTH = irpcp_pkg::STORE_DEPTH_DEF
) (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    input  irpcp_pkg::t_qhead                  i_head,
    output logic                               o_pop,
    input  wire  [irpcp_pkg::CARRIER_W-1:0]    i_carrier_per,
    input  wire  [irpcp_pkg::CARRIER_W-1:0]    i_carrier_high,
    irpcp_out_if.source                        o_out
);

    localparam int unsigned AW = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
    localparam int unsigned CW = $clog2(STORE_DEPTH + 1);
    localparam int unsigned WW = irpcp_pkg::WORD_W;
    localparam int unsigned PW = irpcp_pkg::CARRIER_W;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN_RD,
        S_SCAN_CHK
    } t_state;

    logic [WW-1:0] mem [STORE_DEPTH];
    logic [WW-1:0] r_rdata;
    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    logic [AW-1:0] mem_raddr;

    t_state        r_state,   n_state;
    logic [CW-1:0] r_fill,    n_fill;
    logic          r_cap,     n_cap;
    logic          r_led,     n_led;
    logic          r_play,    n_play;
    logic [AW-1:0] r_pidx,    n_pidx;
    logic [CW-1:0] r_scan,    n_scan;
    logic [WW-1:0] r_mark,    n_mark;
    logic [WW-1:0] r_space,   n_space;
    logic [PW-1:0] r_phase,   n_phase;
    logic          r_ovalid,  n_ovalid;
    logic          r_ir,      n_ir;
    logic          r_oled,    n_oled;
    logic          r_ev,      n_ev;
    logic [WW-1:0] r_ew,      n_ew;
    logic          r_ign,     n_ign;
    logic          r_oplay,   n_oplay;
    logic          r_done,    n_done;

    logic [PW-1:0] period;
    logic [PW:0]   phase_inc;
    logic [WW-1:0] mark_sub;
    logic [WW-1:0] space_sub;
    logic          emit;
    logic          go_scan;

    assign period    = (i_carrier_per == '0) ? PW'(1) : i_carrier_per;
    assign phase_inc = {1'b0, r_phase} + (PW+1)'(1);
    assign mark_sub  = (r_mark > WW'(period)) ? (r_mark - WW'(period)) : '0;
    assign space_sub = (r_space != '0) ? (r_space - WW'(1)) : '0;

    always_comb begin
        n_state  = r_state;
        n_fill   = r_fill;
        n_cap    = r_cap;
        n_led    = r_led;
        n_play   = r_play;
        n_pidx   = r_pidx;
        n_scan   = r_scan;
        n_mark   = r_mark;
        n_space  = r_space;
        n_phase  = r_phase;
        n_ovalid = r_ovalid;
        n_ir     = r_ir;
        n_oled   = r_oled;
        n_ev     = r_ev;
        n_ew     = r_ew;
        n_ign    = r_ign;
        n_oplay  = r_oplay;
        n_done   = r_done;
        o_pop     = 1'b0;
        mem_we    = 1'b0;
        mem_waddr = r_fill[AW-1:0];
        mem_raddr = r_scan[AW-1:0];
        emit      = 1'b0;
        go_scan   = 1'b0;

        if (r_ovalid && o_out.ready) begin
            n_ovalid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (i_head.valid && !r_ovalid) begin
                    o_pop  = 1'b1;
                    n_ir   = 1'b0;
                    n_ev   = 1'b0;
                    n_ew   = '0;
                    n_ign  = 1'b0;
                    n_done = 1'b0;
                    if (i_head.cmd.kind == irpcp_pkg::K_TICK) begin
                        if (r_play && !r_pidx[0]) begin
                            n_ir = (r_phase < i_carrier_high);
                            if (phase_inc >= {1'b0, period}) begin
                                n_phase = '0;
                                n_mark  = mark_sub;
                                if (mark_sub == '0) begin
                                    go_scan = 1'b1;
                                end
                            end else begin
                                n_phase = phase_inc[PW-1:0];
                            end
                        end else if (r_play) begin
                            n_space = space_sub;
                            if (space_sub == '0) begin
                                go_scan = 1'b1;
                            end
                        end
                        n_scan = CW'(r_pidx) + CW'(1);
                    end else begin
                        n_ev   = 1'b1;
                        n_ew   = i_head.cmd.word;
                        n_scan = '0;
                        if (r_play) begin
                            n_ign = 1'b1;
                        end else begin
                            case (i_head.cmd.kind)
                                irpcp_pkg::K_START: begin
                                    n_led  = 1'b1;
                                    n_cap  = 1'b1;
                                    n_fill = '0;
                                end
                                irpcp_pkg::K_STOP: begin
                                    n_led   = 1'b0;
                                    n_cap   = 1'b0;
                                    n_play  = 1'b1;
                                    go_scan = 1'b1;
                                end
                                default: begin
                                    if (r_cap && (r_fill < CW'(STORE_DEPTH))) begin
                                        mem_we = 1'b1;
                                        n_fill = r_fill + CW'(1);
                                    end
                                end
                            endcase
                        end
                    end
                    if (go_scan) begin
                        n_state = S_SCAN_RD;
                    end else begin
                        emit = 1'b1;
                    end
                end
            end
            S_SCAN_RD: begin
                if (r_scan < r_fill) begin
                    n_state = S_SCAN_CHK;
                end else begin
                    n_play  = 1'b0;
                    n_pidx  = '0;
                    n_mark  = '0;
                    n_space = '0;
                    n_phase = '0;
                    n_done  = 1'b1;
                    emit    = 1'b1;
                    n_state = S_IDLE;
                end
            end
            S_SCAN_CHK: begin
                if (r_rdata != '0) begin
                    n_pidx  = r_scan[AW-1:0];
                    n_phase = '0;
                    if (!r_scan[0]) begin
                        n_mark  = r_rdata;
                        n_space = '0;
                    end else begin
                        n_space = r_rdata;
                        n_mark  = '0;
                    end
                    emit    = 1'b1;
                    n_state = S_IDLE;
                end else begin
                    n_scan  = r_scan + CW'(1);
                    n_state = S_SCAN_RD;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (emit) begin
            n_ovalid = 1'b1;
            n_oled   = n_led;
            n_oplay  = n_play;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_waddr] <= i_head.cmd.word;
        end
        r_rdata <= mem[mem_raddr];
    end

    always_ff @(posedge i_clk) begin
        r_scan  <= n_scan;
        r_ir    <= n_ir;
        r_oled  <= n_oled;
        r_ev    <= n_ev;
        r_ew    <= n_ew;
        r_ign   <= n_ign;
        r_oplay <= n_oplay;
        r_done  <= n_done;
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_fill   <= '0;
            r_cap    <= 1'b0;
            r_led    <= 1'b0;
            r_play   <= 1'b0;
            r_ovalid <= 1'b0;
            r_pidx   <= '0;
            r_mark   <= '0;
            r_space  <= '0;
            r_phase  <= '0;
        end else begin
            r_state  <= n_state;
            r_fill   <= n_fill;
            r_cap    <= n_cap;
            r_led    <= n_led;
            r_play   <= n_play;
            r_ovalid <= n_ovalid;
            r_pidx   <= n_pidx;
            r_mark   <= n_mark;
            r_space  <= n_space;
            r_phase  <= n_phase;
        end
    end

    assign o_out.valid        = r_ovalid;
    assign o_out.ir_drive     = r_ir;
    assign o_out.capture_led  = r_oled;
    assign o_out.echo_valid   = r_ev;
    assign o_out.echo_word    = r_ew;
    assign o_out.word_ignored = r_ign;
    assign o_out.playing      = r_oplay;
    assign o_out.done_res     = r_done;

endmodule

`default_nettype wire

// ===== rtl/ir_pattern_capture_and_playback_unit.sv =====
// IR pattern capture and playback unit.
// i_in carries one request per microsecond tick (operation = 1) or per received
// word (operation = 0, word_in). o_out returns exactly one result per request:
// emitter level, capture LED, echo of the word, ignored / playing / done flags.
// Configuration is written through i_cfg_we / i_cfg_idx / i_cfg_data: start
// marker, stop marker, carrier period and carrier high time. The user must
// write it only while idle; the unit itself does not enforce this. A two-entry
// queue sits between the input classifier and the execution unit, so requests
// are taken while a result waits in the output register. A request passes
// through the queue and then the output register; the execution unit takes
// the next request from the queue only once the output register is empty.
// The stop marker and the end of each segment search the store for the next
// nonzero entry, with one memory read and one check per entry examined.
// When o_out stalls, the result holds, the queue fills and i_in.ready drops.
// Reset restores the configuration defaults and clears capture, LED and
// playback state; the pattern store needs no clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module ir_pattern_capture_and_playback_unit #(
    parameter int unsigned STORE_DEPTH = irpcp_pkg::STORE_DEPTH_DEF
) (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    irpcp_in_if.sink                           i_in,
    irpcp_out_if.source                        o_out,
    input  wire                                i_cfg_we,
    input  wire  [irpcp_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  wire  [irpcp_pkg::WORD_W-1:0]       i_cfg_data
);

    logic [irpcp_pkg::WORD_W-1:0]    r_start_marker;
    logic [irpcp_pkg::WORD_W-1:0]    r_stop_marker;
    logic [irpcp_pkg::CARRIER_W-1:0] r_carrier_per;
    logic [irpcp_pkg::CARRIER_W-1:0] r_carrier_high;
    irpcp_pkg::t_qhead               head;
    logic                            pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_marker <= irpcp_pkg::START_MARKER_RST;
            r_stop_marker  <= irpcp_pkg::STOP_MARKER_RST;
            r_carrier_per  <= irpcp_pkg::CARRIER_PER_RST;
            r_carrier_high <= irpcp_pkg::CARRIER_HIGH_RST;
        end else if (i_cfg_we) begin
            case (irpcp_pkg::t_cfg_reg'(i_cfg_idx))
                irpcp_pkg::CFG_START_MARKER: r_start_marker <= i_cfg_data;
                irpcp_pkg::CFG_STOP_MARKER:  r_stop_marker  <= i_cfg_data;
                irpcp_pkg::CFG_CARRIER_PER:
                    r_carrier_per  <= i_cfg_data[irpcp_pkg::CARRIER_W-1:0];
                irpcp_pkg::CFG_CARRIER_HIGH:
                    r_carrier_high <= i_cfg_data[irpcp_pkg::CARRIER_W-1:0];
                default: begin
                end
            endcase
        end
    end

    irpcp_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in           (i_in),
        .i_start_marker (r_start_marker),
        .i_stop_marker  (r_stop_marker),
        .i_pop          (pop),
        .o_head         (head)
    );

    irpcp_back #(
        .STORE_DEPTH (STORE_DEPTH)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_head         (head),
        .o_pop          (pop),
        .i_carrier_per  (r_carrier_per),
        .i_carrier_high (r_carrier_high),
        .o_out          (o_out)
    );

    a_ignored_only_in_playback: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && o_out.word_ignored |-> o_out.echo_valid && o_out.playing)
        else $error("ignored word outside playback");

    a_done_ends_playback: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && o_out.done_res |-> !o_out.playing && !o_out.capture_led)
        else $error("done flagged while playing or capturing");

    a_word_drives_no_ir: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && o_out.echo_valid |-> !o_out.ir_drive)
        else $error("emitter driven on a word result");

    a_led_off_in_playback: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> !(o_out.capture_led && o_out.playing))
        else $error("capture LED on during playback");

endmodule

`default_nettype wire

// ===== bench/tb_ir_pattern_capture_and_playback_unit.sv =====
`timescale 1ns / 1ps

module tb_ir_pattern_capture_and_playback_unit;

    localparam int unsigned DEPTH       = irpcp_pkg::STORE_DEPTH_DEF;
    localparam logic        OP_WORD     = 1'b0;
    localparam logic        OP_TICK     = 1'b1;
    localparam int          HOLD_CYCLES = 80;
    localparam int unsigned ITEM_TARGET = 1050;
    localparam int unsigned QUIET_AFTER = 900;

    typedef struct packed {
        logic        ir_drive;
        logic        capture_led;
        logic        echo_valid;
        logic [15:0] echo_word;
        logic        word_ignored;
        logic        playing;
        logic        done_res;
    } t_emit_resp;

    logic                            i_clk = 1'b0;
    logic                            i_rst_n;
    logic                            i_cfg_we;
    logic [irpcp_pkg::CFG_IDX_W-1:0] i_cfg_idx;
    logic [irpcp_pkg::WORD_W-1:0]    i_cfg_data;

    irpcp_in_if  in_ch ();
    irpcp_out_if out_ch ();

    ir_pattern_capture_and_playback_unit DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (in_ch),
        .o_out      (out_ch),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    logic [15:0] pattern_mem [DEPTH];
    int unsigned fill_cnt;
    int unsigned play_idx;
    int unsigned mark_rem;
    int unsigned space_rem;
    int unsigned carrier_ph;
    bit          capture_on;
    bit          led_on;
    bit          play_on;
    logic [15:0] start_mk;
    logic [15:0] stop_mk;
    logic [7:0]  car_per;
    logic [7:0]  car_high;

    t_emit_resp  emitter_resp_q [$];
    int unsigned fault_cnt = 0;
    int unsigned resp_idx  = 0;
    int unsigned sent_cnt  = 0;
    bit          idle_on   = 1'b0;
    bit          hold_req  = 1'b0;

    function automatic bit load_next(input int unsigned from);
        int unsigned k;
        for (k = from; k < fill_cnt && k < DEPTH; k++) begin
            if (pattern_mem[k] != 16'd0) begin
                play_idx   = k;
                carrier_ph = 0;
                mark_rem   = (k % 2 == 0) ? pattern_mem[k] : 0;
                space_rem  = (k % 2 == 0) ? 0 : pattern_mem[k];
                return 1'b1;
            end
        end
        play_on    = 1'b0;
        play_idx   = 0;
        mark_rem   = 0;
        space_rem  = 0;
        carrier_ph = 0;
        return 1'b0;
    endfunction

    function automatic t_emit_resp step_emitter(input logic op, input logic [15:0] w);
        t_emit_resp  r;
        int unsigned per;
        r = '0;
        if (op == OP_WORD) begin
            r.echo_valid = 1'b1;
            r.echo_word  = w;
            if (play_on) begin
                r.word_ignored = 1'b1;
            end else if (w == start_mk) begin
                led_on     = 1'b1;
                capture_on = 1'b1;
                fill_cnt   = 0;
            end else if (w == stop_mk) begin
                led_on     = 1'b0;
                capture_on = 1'b0;
                play_on    = 1'b1;
                if (!load_next(0))
                    r.done_res = 1'b1;
            end else if (capture_on && fill_cnt < DEPTH) begin
                pattern_mem[fill_cnt] = w;
                fill_cnt++;
            end
        end else if (play_on) begin
            if (play_idx % 2 == 0) begin
                per        = (car_per == 8'd0) ? 1 : car_per;
                r.ir_drive = (carrier_ph < car_high);
                carrier_ph++;
                if (carrier_ph >= per) begin
                    carrier_ph = 0;
                    mark_rem   = (mark_rem > per) ? mark_rem - per : 0;
                    if (mark_rem == 0 && !load_next(play_idx + 1))
                        r.done_res = 1'b1;
                end
            end else begin
                if (space_rem > 0)
                    space_rem--;
                if (space_rem == 0 && !load_next(play_idx + 1))
                    r.done_res = 1'b1;
            end
        end
        r.capture_led = led_on;
        r.playing     = play_on;
        return r;
    endfunction

    function automatic logic [15:0] pick_duration();
        int unsigned roll;
        roll = $urandom_range(0, 19);
        if (roll < 3)
            return 16'd0;
        if (roll == 19)
            return 16'($urandom_range(25, 60));
        return 16'($urandom_range(1, 24));
    endfunction

    function automatic logic [15:0] noise_word();
        logic [15:0] w;
        w = 16'($urandom);
        if ($urandom_range(0, 5) == 0)
            w = $urandom_range(0, 1) ? start_mk : stop_mk;
        else if (capture_on && w != start_mk && w != stop_mk)
            w = pick_duration();
        return w;
    endfunction

    task automatic send_req(input logic op, input logic [15:0] w);
        if (idle_on && $urandom_range(0, 3) == 0) begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge i_clk);
        end
        in_ch.valid     <= 1'b1;
        in_ch.operation <= op;
        in_ch.word_in   <= w;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        sent_cnt++;
        emitter_resp_q.push_back(step_emitter(op, w));
    endtask

    task automatic wait_drained();
        in_ch.valid <= 1'b0;
        do
            @(posedge i_clk);
        while (emitter_resp_q.size() != 0);
    endtask

    task automatic cfg_write(input irpcp_pkg::t_cfg_reg idx, input logic [15:0] val);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            irpcp_pkg::CFG_START_MARKER: start_mk = val;
            irpcp_pkg::CFG_STOP_MARKER:  stop_mk  = val;
            irpcp_pkg::CFG_CARRIER_PER:  car_per  = val[7:0];
            irpcp_pkg::CFG_CARRIER_HIGH: car_high = val[7:0];
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    task automatic play_out();
        while (play_on) begin
            if ($urandom_range(0, 9) == 0)
                send_req(OP_WORD, 16'($urandom));
            else
                send_req(OP_TICK, 16'($urandom));
        end
    endtask

    task automatic play_pattern(input int n, input logic [63:0] durs);
        send_req(OP_WORD, start_mk);
        for (int i = 0; i < n; i++)
            send_req(OP_WORD, durs[16*i +: 16]);
        send_req(OP_WORD, stop_mk);
        play_out();
        wait_drained();
    endtask

    task automatic test_directed();
        idle_on = 1'b1;
        send_req(OP_TICK, 16'hFFFF);
        send_req(OP_WORD, 16'hFFFF);
        send_req(OP_WORD, 16'h0000);
        send_req(OP_WORD, stop_mk);
        send_req(OP_WORD, start_mk);
        send_req(OP_WORD, 16'd1);
        send_req(OP_WORD, 16'd0);
        send_req(OP_WORD, 16'd0);
        send_req(OP_WORD, 16'd3);
        send_req(OP_WORD, stop_mk);
        send_req(OP_WORD, start_mk);
        send_req(OP_WORD, stop_mk);
        play_out();
        send_req(OP_WORD, 16'd5);
        send_req(OP_WORD, stop_mk);
        play_out();
        send_req(OP_WORD, start_mk);
        send_req(OP_WORD, 16'd0);
        send_req(OP_WORD, stop_mk);
        wait_drained();
    endtask

    task automatic test_carrier_extremes();
        cfg_write(irpcp_pkg::CFG_CARRIER_PER, 16'd255);
        cfg_write(irpcp_pkg::CFG_CARRIER_HIGH, 16'd254);
        cfg_write(irpcp_pkg::CFG_START_MARKER, 16'h0000);
        cfg_write(irpcp_pkg::CFG_STOP_MARKER, 16'hFFFF);
        play_pattern(2, {16'd1, 16'd1});
        cfg_write(irpcp_pkg::CFG_CARRIER_PER, 16'd2);
        play_pattern(4, {16'd1, 16'd2, 16'd2, 16'd3});
        cfg_write(irpcp_pkg::CFG_CARRIER_HIGH, 16'd1);
        cfg_write(irpcp_pkg::CFG_START_MARKER, 16'hFFFF);
        cfg_write(irpcp_pkg::CFG_STOP_MARKER, 16'h0000);
        play_pattern(3, {16'd2, 16'd5, 16'd1});
    endtask

    task automatic test_store_full();
        cfg_write(irpcp_pkg::CFG_START_MARKER, irpcp_pkg::START_MARKER_RST);
        cfg_write(irpcp_pkg::CFG_STOP_MARKER, irpcp_pkg::STOP_MARKER_RST);
        send_req(OP_WORD, start_mk);
        repeat (DEPTH + 8)
            send_req(OP_WORD, ($urandom_range(0, 7) == 0) ?
                              16'($urandom_range(1, 2)) : 16'd0);
        send_req(OP_WORD, stop_mk);
        play_out();
        play_pattern(2, {16'd1, 16'd2});
    endtask

    task automatic test_backpressure();
        idle_on = 1'b0;
        wait_drained();
        cfg_write(irpcp_pkg::CFG_CARRIER_PER, 16'd3);
        cfg_write(irpcp_pkg::CFG_CARRIER_HIGH, 16'd2);
        send_req(OP_WORD, start_mk);
        send_req(OP_WORD, 16'd4);
        send_req(OP_WORD, 16'd2);
        send_req(OP_WORD, 16'd5);
        send_req(OP_WORD, stop_mk);
        hold_req = 1'b1;
        repeat (12)
            send_req(OP_TICK, 16'($urandom));
        wait_drained();
        play_out();
        wait_drained();
    endtask

    task automatic test_random();
        int unsigned kind;
        int unsigned n;
        logic [15:0] mk;
        while (sent_cnt < ITEM_TARGET) begin
            wait_drained();
            idle_on = (sent_cnt < QUIET_AFTER) && ($urandom_range(0, 3) != 0);
            if ($urandom_range(0, 3) == 0) begin
                n = $urandom_range(2, ($urandom_range(0, 9) == 0) ? 40 : 6);
                cfg_write(irpcp_pkg::CFG_CARRIER_PER, 16'(n));
                cfg_write(irpcp_pkg::CFG_CARRIER_HIGH, 16'($urandom_range(1, n + 1)));
            end
            if ($urandom_range(0, 4) == 0) begin
                mk = 16'($urandom);
                cfg_write(irpcp_pkg::CFG_START_MARKER, mk);
                cfg_write(irpcp_pkg::CFG_STOP_MARKER, mk ^ 16'($urandom_range(1, 65535)));
            end
            kind = $urandom_range(0, 9);
            if (kind < 7) begin
                send_req(OP_WORD, start_mk);
                repeat ($urandom_range(1, 8)) begin
                    if ($urandom_range(0, 5) == 0)
                        send_req(OP_TICK, 16'($urandom));
                    send_req(OP_WORD, pick_duration());
                end
                send_req(OP_WORD, stop_mk);
            end else if (kind == 7) begin
                send_req(OP_WORD, start_mk);
                repeat ($urandom_range(1, 4))
                    send_req(OP_WORD, pick_duration());
                send_req(OP_WORD, start_mk);
                repeat ($urandom_range(1, 4))
                    send_req(OP_WORD, pick_duration());
                send_req(OP_WORD, stop_mk);
            end else if (kind == 8) begin
                if ($urandom_range(0, 1) == 0) begin
                    send_req(OP_WORD, stop_mk);
                end else begin
                    send_req(OP_WORD, start_mk);
                    repeat ($urandom_range(1, 4))
                        send_req(OP_WORD, pick_duration());
                end
            end else begin
                repeat ($urandom_range(2, 8)) begin
                    if ($urandom_range(0, 1) == 0)
                        send_req(OP_TICK, 16'($urandom));
                    else
                        send_req(OP_WORD, noise_word());
                end
            end
            play_out();
        end
    endtask

    initial begin : result_sink
        int         stall_left;
        int         hold_left;
        t_emit_resp got;
        t_emit_resp want;
        stall_left = 0;
        hold_left  = 0;
        out_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && out_ch.valid && out_ch.ready) begin
                got = {out_ch.ir_drive, out_ch.capture_led, out_ch.echo_valid,
                       out_ch.echo_word, out_ch.word_ignored, out_ch.playing,
                       out_ch.done_res};
                if (emitter_resp_q.size() == 0) begin
                    fault_cnt++;
                    if (fault_cnt <= 10)
                        $display("result %0d arrived with nothing expected: %h", resp_idx, got);
                end else begin
                    want = emitter_resp_q.pop_front();
                    if (got !== want) begin
                        fault_cnt++;
                        if (fault_cnt <= 10) begin
                            $display("result %0d: expected ir=%b led=%b ev=%b ew=%h ign=%b play=%b done=%b",
                                     resp_idx, want.ir_drive, want.capture_led,
                                     want.echo_valid, want.echo_word, want.word_ignored,
                                     want.playing, want.done_res);
                            $display("result %0d: got      ir=%b led=%b ev=%b ew=%h ign=%b play=%b done=%b",
                                     resp_idx, got.ir_drive, got.capture_led,
                                     got.echo_valid, got.echo_word, got.word_ignored,
                                     got.playing, got.done_res);
                        end
                    end
                end
                resp_idx++;
            end
            if (hold_req) begin
                hold_left = HOLD_CYCLES;
                hold_req  = 1'b0;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_ch.ready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                out_ch.ready <= 1'b0;
            end else if (idle_on && $urandom_range(0, 7) == 0) begin
                stall_left = $urandom_range(0, 13);
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= 1'b1;
            end
        end
    end

    initial begin
        #20_000_000;
        $display("end of test: mismatches");
        $finish;
    end

    initial begin
        fill_cnt   = 0;
        play_idx   = 0;
        mark_rem   = 0;
        space_rem  = 0;
        carrier_ph = 0;
        capture_on = 1'b0;
        led_on     = 1'b0;
        play_on    = 1'b0;
        start_mk   = irpcp_pkg::START_MARKER_RST;
        stop_mk    = irpcp_pkg::STOP_MARKER_RST;
        car_per    = irpcp_pkg::CARRIER_PER_RST;
        car_high   = irpcp_pkg::CARRIER_HIGH_RST;
        i_rst_n         <= 1'b0;
        i_cfg_we        <= 1'b0;
        i_cfg_idx       <= irpcp_pkg::CFG_START_MARKER;
        i_cfg_data      <= '0;
        in_ch.valid     <= 1'b0;
        in_ch.operation <= OP_WORD;
        in_ch.word_in   <= '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_carrier_extremes();
        test_store_full();
        test_backpressure();
        test_random();
        wait_drained();
        repeat (2 * DEPTH + 8) @(posedge i_clk);
        if (fault_cnt == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/irpcp_pkg.sv
rtl/irpcp_in_if.sv
rtl/irpcp_out_if.sv
rtl/irpcp_front.sv
rtl/irpcp_back.sv
rtl/ir_pattern_capture_and_playback_unit.sv
bench/tb_ir_pattern_capture_and_playback_unit.sv
